// File: rtl/core/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants for the frustum cull test.
// ----------------------------------------------------------------------------
package fct_pkg;

    localparam int PLANE_COUNT     = 6;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int PLANE_W         = 64;
    localparam int NORM_W          = 16;
    localparam int HALF_W          = 15;
    localparam int SAXIS_W         = 31;
    localparam int FRAC_SHIFT      = 14;
    localparam int LATENCY         = 1 + 2 * PLANE_COUNT;

    localparam logic [1:0] FUNC_POINT  = 2'd0;
    localparam logic [1:0] FUNC_SPHERE = 2'd1;
    localparam logic [1:0] FUNC_BOX    = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] PLANE_REG_IDX [PLANE_COUNT] = '{
        REG_PLANE_NEAR, REG_PLANE_FAR, REG_PLANE_LEFT,
        REG_PLANE_RIGHT, REG_PLANE_BOTTOM, REG_PLANE_TOP
    };

    // Object data carried down the cell row; s holds axis * half extent.
    typedef struct packed {
        logic [1:0]                     func;
        logic                           in_view;
        logic [HALF_W-1:0]              radius;
        logic [2:0][2:0][SAXIS_W-1:0]   s;
    } t_item;

endpackage

// File: rtl/core/fct_prep.sv
// ----------------------------------------------------------------------------
// fct_prep
// Input stage: captures a transaction and scales the box axes by extents.
// ----------------------------------------------------------------------------
module fct_prep #(
    parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    input  logic [1:0]                         i_func,
    input  logic [2:0][COORD_WIDTH-1:0]        i_p,
    input  logic [fct_pkg::HALF_W-1:0]         i_radius,
    input  logic [2:0][47:0]                   i_axis,
    input  logic [2:0][fct_pkg::HALF_W-1:0]    i_half,
    output logic                               o_vld,
    output fct_pkg::t_item                     o_item,
    output logic [2:0][COORD_WIDTH-1:0]        o_p
);
    import fct_pkg::*;

    logic                         r_vld;
    t_item                        r_item;
    logic [2:0][COORD_WIDTH-1:0]  r_p;
    t_item                        n_item;
    logic signed [2*NORM_W-1:0]   prod [3][3];

    always_comb begin
        n_item         = '0;
        n_item.func    = i_func;
        n_item.in_view = 1'b1;
        n_item.radius  = i_radius;
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                prod[j][k]     = $signed(i_axis[j][16*k +: 16])
                               * $signed({1'b0, i_half[j]});
                n_item.s[j][k] = prod[j][k][SAXIS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_item <= n_item;
            r_p    <= i_p;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;
    assign o_p    = r_p;

endmodule

// File: rtl/core/fct_cell.sv
// ----------------------------------------------------------------------------
// fct_cell
// One plane of the frustum: holds the plane register and tests the passing
// object against it in two stages (products, then sums and compare).
// ----------------------------------------------------------------------------
module fct_cell #(
    parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fct_pkg::PLANE_W-1:0]        i_cfg_data,
    input  logic                               i_vld,
    input  fct_pkg::t_item                     i_item,
    input  logic [2:0][COORD_WIDTH-1:0]        i_p,
    output logic                               o_vld,
    output fct_pkg::t_item                     o_item,
    output logic [2:0][COORD_WIDTH-1:0]        o_p
);
    import fct_pkg::*;

    localparam int PN_W  = NORM_W + COORD_WIDTH;
    localparam int OFS_W = NORM_W + FRAC_SHIFT;
    localparam int DW    = ((PN_W > OFS_W) ? PN_W : OFS_W) + 2;
    localparam int PR_W  = NORM_W + SAXIS_W;
    localparam int PS_W  = PR_W + 2;
    localparam int SUM_W = PS_W + 2;
    localparam int CW    = (((DW + FRAC_SHIFT) > SUM_W) ? (DW + FRAC_SHIFT) : SUM_W) + 1;

    logic [PLANE_W-1:0]           r_plane;

    // stage A
    logic                         r_vld_a;
    t_item                        r_item_a;
    logic [2:0][COORD_WIDTH-1:0]  r_p_a;
    logic signed [PN_W-1:0]       r_pn [3];
    logic signed [PR_W-1:0]       r_pr [3][3];
    logic signed [NORM_W-1:0]     r_ofs;

    // stage B
    logic                         r_vld_b;
    t_item                        r_item_b;
    logic [2:0][COORD_WIDTH-1:0]  r_p_b;

    logic signed [DW-1:0]         pdist;
    logic signed [DW-1:0]         ofs_s;
    logic signed [PS_W-1:0]       ps [3];
    logic [PS_W-1:0]              mag [3];
    logic [SUM_W-1:0]             sum;
    logic signed [CW-1:0]         d_cmp;
    logic signed [CW-1:0]         sum_cmp;
    logic signed [DW-1:0]         rad_cmp;
    logic                         reject;
    t_item                        n_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_cfg_we) begin
            r_plane <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_item_a <= i_item;
            r_p_a    <= i_p;
            r_ofs    <= $signed(r_plane[63:48]);
            for (int k = 0; k < 3; k++) begin
                r_pn[k] <= $signed(r_plane[16*k +: 16]) * $signed(i_p[k]);
                for (int j = 0; j < 3; j++) begin
                    r_pr[j][k] <= $signed(r_plane[16*k +: 16]) * $signed(i_item.s[j][k]);
                end
            end
        end
    end

    always_comb begin
        ofs_s = DW'(r_ofs);
        pdist = DW'(r_pn[0]) + DW'(r_pn[1]) + DW'(r_pn[2]) + (ofs_s <<< FRAC_SHIFT);
        for (int j = 0; j < 3; j++) begin
            ps[j]  = PS_W'(r_pr[j][0]) + PS_W'(r_pr[j][1]) + PS_W'(r_pr[j][2]);
            mag[j] = ps[j][PS_W-1] ? PS_W'(-ps[j]) : PS_W'(ps[j]);
        end
        sum     = SUM_W'(mag[0]) + SUM_W'(mag[1]) + SUM_W'(mag[2]);
        d_cmp   = CW'(pdist) <<< FRAC_SHIFT;
        sum_cmp = $signed(CW'(sum));
        rad_cmp = $signed(DW'({r_item_a.radius, {FRAC_SHIFT{1'b0}}}));
        unique case (r_item_a.func)
            FUNC_POINT:  reject = pdist > $signed(DW'(0));
            FUNC_SPHERE: reject = pdist >= rad_cmp;
            FUNC_BOX:    reject = d_cmp >= sum_cmp;
            default:     reject = 1'b0;
        endcase
        n_item         = r_item_a;
        n_item.in_view = r_item_a.in_view & ~reject;
    end

    always_ff @(posedge i_clk) begin
        if (r_vld_a) begin
            r_item_b <= n_item;
            r_p_b    <= r_p_a;
        end
    end

    assign o_vld  = r_vld_b;
    assign o_item = r_item_b;
    assign o_p    = r_p_b;

endmodule

// File: rtl/core/frustum_cull_test.sv
// ----------------------------------------------------------------------------
// frustum_cull_test
// View frustum culling of points, spheres and oriented boxes (or no test)
// against six configured planes, one object per clock.
// ----------------------------------------------------------------------------
// Command channel: an object transaction is taken when i_start is high and
//   o_busy is low. o_busy stays low, so a new object may start every cycle.
// Result channel: o_done pulses for one cycle with o_inside_res; the receiver
//   has no back-pressure and must take it in that cycle.
// Pipeline: one input stage plus six plane cells of two stages each lie
//   between an accepted object and its result. Throughput is one object
//   per cycle.
// Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index selecting near,
//   far, left, right, bottom, top (0..5); other indexes are dropped. Write
//   only while no object is in flight. o_cfg_ready is always high.
// Reset: i_rst_n low clears all planes to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module frustum_cull_test #(
    parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [1:0]                         i_func,
    input  logic [COORD_WIDTH-1:0]             i_pos_x,
    input  logic [COORD_WIDTH-1:0]             i_pos_y,
    input  logic [COORD_WIDTH-1:0]             i_pos_z,
    input  logic [fct_pkg::HALF_W-1:0]         i_radius,
    input  logic [47:0]                        i_axis_a,
    input  logic [47:0]                        i_axis_b,
    input  logic [47:0]                        i_axis_c,
    input  logic [fct_pkg::HALF_W-1:0]         i_half_a,
    input  logic [fct_pkg::HALF_W-1:0]         i_half_b,
    input  logic [fct_pkg::HALF_W-1:0]         i_half_c,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fct_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fct_pkg::PLANE_W-1:0]        i_cfg_data,
    output logic                               o_done,
    output logic                               o_inside_res
);
    import fct_pkg::*;

    logic                         vld  [PLANE_COUNT+1];
    t_item                        item [PLANE_COUNT+1];
    logic [2:0][COORD_WIDTH-1:0]  pp   [PLANE_COUNT+1];
    logic                         accept;
    logic                         cfg_fire;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start & ~o_busy;
    assign cfg_fire    = i_cfg_valid & o_cfg_ready;

    fct_prep #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (accept),
        .i_func   (i_func),
        .i_p      ({i_pos_z, i_pos_y, i_pos_x}),
        .i_radius (i_radius),
        .i_axis   ({i_axis_c, i_axis_b, i_axis_a}),
        .i_half   ({i_half_c, i_half_b, i_half_a}),
        .o_vld    (vld[0]),
        .o_item   (item[0]),
        .o_p      (pp[0])
    );

    for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
        fct_cell #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cfg_we   (cfg_fire && (i_cfg_index == PLANE_REG_IDX[i])),
            .i_cfg_data (i_cfg_data),
            .i_vld      (vld[i]),
            .i_item     (item[i]),
            .i_p        (pp[i]),
            .o_vld      (vld[i+1]),
            .o_item     (item[i+1]),
            .o_p        (pp[i+1])
        );
    end

    assign o_done       = vld[PLANE_COUNT];
    assign o_inside_res = item[PLANE_COUNT].in_view;

endmodule

// File: rtl/core/fct_checker.sv
// ----------------------------------------------------------------------------
// fct_checker
// Port-level checks for frustum_cull_test: fixed latency, no-test result and config no-stall.
// ----------------------------------------------------------------------------
module fct_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               o_busy,
    input  logic [1:0]                         i_func,
    input  logic                               i_cfg_valid,
    input  logic                               o_cfg_ready,
    input  logic                               o_done,
    input  logic                               o_inside_res
);
    import fct_pkg::*;

    logic accept;

    assign accept = i_start & ~o_busy;

    a_done_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LATENCY))
        else $error("result without a command");

    a_cmd_gets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_done)
        else $error("command result missing");

    a_none_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_func == FUNC_NONE)) |-> ##LATENCY o_inside_res)
        else $error("no-test command rejected");

    a_cfg_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && !o_busy) |-> o_cfg_ready)
        else $error("config write stalled");

endmodule

bind frustum_cull_test fct_checker u_fct_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .i_func       (i_func),
    .i_cfg_valid  (i_cfg_valid),
    .o_cfg_ready  (o_cfg_ready),
    .o_done       (o_done),
    .o_inside_res (o_inside_res)
);
